// ===== rtl/htfd_pkg.sv =====
// ----------------------------------------------------------------------------
// htfd_pkg
// Shared constants and the CRC-8 byte update of the measurement frame decoder.
// ----------------------------------------------------------------------------
package htfd_pkg;

    // CRC-8 with polynomial x^8 + x^5 + x^4 + 1, no reflection, no final XOR.
    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_POLY = 8'h31;

    // Position of the next byte within the six-byte frame.
    typedef logic [2:0] pos_t;
    localparam pos_t POS_TEMP_MSB = 3'd0;
    localparam pos_t POS_TEMP_LSB = 3'd1;
    localparam pos_t POS_TEMP_CRC = 3'd2;
    localparam pos_t POS_HUM_MSB  = 3'd3;
    localparam pos_t POS_HUM_LSB  = 3'd4;
    localparam pos_t POS_HUM_CRC  = 3'd5;

    // Scale factors and offsets of the conversions, in hundredths.
    // The temperature product 17500 * 65535 needs the full 31 bits.
    localparam int PROD_W = 31;
    localparam logic [14:0] TEMP_SCALE  = 15'd17500;
    localparam logic [14:0] HUM_SCALE   = 15'd12500;
    localparam logic [15:0] TEMP_OFFSET = 16'd4500;
    localparam logic [14:0] HUM_OFFSET  = 15'd600;
    localparam logic [13:0] HUM_MAX     = 14'd10000;

    typedef logic [PROD_W-1:0] prod_t;

    // One byte through the CRC register, eight shift steps.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

    // floor(x / 65535), exact for x below 32768 * 65535, as the quotient has 15 bits.
    function automatic logic [14:0] div65535(input prod_t x);
        logic [PROD_W:0] s;
        s = {1'b0, x} + {17'd0, x[PROD_W-1:16]} + {{PROD_W{1'b0}}, 1'b1};
        return s[30:16];
    endfunction

endpackage

// ===== rtl/humidity_temp_frame_decoder.sv =====
// ----------------------------------------------------------------------------
// humidity_temp_frame_decoder
// Six-byte measurement frame decoder with CRC-8 word checks and conversion.
// ----------------------------------------------------------------------------
// A result reaches the master side from the sixth byte of a frame through the
// frame stage, the product stage and the output register.
// Throughput: one byte per cycle while s_tready is high; the rate is set by the
// CRC update of the frame register, every later stage being a plain pipeline.
// Reset (aresetn low, synchronous): byte position 0, CRC 0xFF, raw words and
// flags cleared, all pipeline stages empty.
// ----------------------------------------------------------------------------
module humidity_temp_frame_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    // Input channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic [0:0]  s_tuser,   // [0] frame_start
    // Result channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [14:0] temperature_centi, [28:15] humidity_centi,
                                   // [31:29] zero
    output logic [1:0]  m_tuser    // [0] temp_crc_ok, [1] hum_crc_ok
);
    import htfd_pkg::*;

    // ------------------------------------------------------------------------
    // Frame state. These registers take each transferred byte directly: the
    // byte position, the running CRC of the current word and the raw words.
    // ------------------------------------------------------------------------
    pos_t        pos_reg, pos_next;
    logic [7:0]  crc_reg, crc_next;
    logic [15:0] traw_reg, traw_next;
    logic [15:0] hraw_reg, hraw_next;
    logic        tok_reg, tok_next;

    // Stage 1: a completed frame, its raw words and its two CRC verdicts.
    logic        p1_valid_reg;
    logic [15:0] p1_traw_reg;
    logic [15:0] p1_hraw_reg;
    logic        p1_tok_reg;
    logic        p1_hok_reg;

    // Stage 2: the two scaled products.
    logic        p2_valid_reg;
    prod_t       p2_tprod_reg;
    prod_t       p2_hprod_reg;
    logic        p2_tok_reg;
    logic        p2_hok_reg;

    // Output register.
    logic        out_valid_reg;
    logic [14:0] out_temp_reg, out_temp_next;
    logic [13:0] out_hum_reg, out_hum_next;
    logic        out_tok_reg;
    logic        out_hok_reg;

    logic        out_ready, p2_ready, p1_ready;
    logic        s_xfer;
    pos_t        pos_eff;
    logic [7:0]  crc_eff;
    logic [7:0]  crc_upd;
    logic        frame_done;
    logic [14:0] tq, hq;
    logic [15:0] temp_wide;

    // Each stage may load when it is empty or its contents move on in the
    // same cycle, so bubbles close up while the output register is held.
    assign out_ready = !out_valid_reg || m_tready;
    assign p2_ready  = !p2_valid_reg || out_ready;
    assign p1_ready  = !p1_valid_reg || p2_ready;
    assign s_tready  = p1_ready;
    assign s_xfer    = s_tvalid && s_tready;

    // A start flag drops any partial frame before the byte is taken as byte 0.
    assign pos_eff = s_tuser[0] ? POS_TEMP_MSB : pos_reg;
    assign crc_eff = s_tuser[0] ? CRC_INIT : crc_reg;
    assign crc_upd = crc8_byte(crc_eff, s_tdata);
    assign frame_done = s_xfer && (pos_eff == POS_HUM_CRC);

    always_comb begin
        pos_next  = pos_reg;
        crc_next  = crc_reg;
        traw_next = traw_reg;
        hraw_next = hraw_reg;
        tok_next  = tok_reg;
        if (s_xfer) begin
            unique case (pos_eff)
                POS_TEMP_MSB: begin
                    traw_next = {s_tdata, traw_reg[7:0]};
                    crc_next  = crc_upd;
                    pos_next  = POS_TEMP_LSB;
                end
                POS_TEMP_LSB: begin
                    traw_next = {traw_reg[15:8], s_tdata};
                    crc_next  = crc_upd;
                    pos_next  = POS_TEMP_CRC;
                end
                POS_TEMP_CRC: begin
                    tok_next = (crc_eff == s_tdata);
                    crc_next = CRC_INIT;
                    pos_next = POS_HUM_MSB;
                end
                POS_HUM_MSB: begin
                    hraw_next = {s_tdata, hraw_reg[7:0]};
                    crc_next  = crc_upd;
                    pos_next  = POS_HUM_LSB;
                end
                POS_HUM_LSB: begin
                    hraw_next = {hraw_reg[15:8], s_tdata};
                    crc_next  = crc_upd;
                    pos_next  = POS_HUM_CRC;
                end
                default: begin
                    // Humidity CRC byte ends the frame; the position wraps.
                    crc_next = CRC_INIT;
                    pos_next = POS_TEMP_MSB;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= POS_TEMP_MSB;
            crc_reg  <= CRC_INIT;
            traw_reg <= '0;
            hraw_reg <= '0;
            tok_reg  <= 1'b0;
        end else begin
            pos_reg  <= pos_next;
            crc_reg  <= crc_next;
            traw_reg <= traw_next;
            hraw_reg <= hraw_next;
            tok_reg  <= tok_next;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 1. The humidity word is already complete when its CRC byte
    // arrives, so the frame is captured from the state registers.
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (p1_ready) begin
            p1_valid_reg <= frame_done;
        end
    end

    always_ff @(posedge aclk) begin
        if (frame_done) begin
            p1_traw_reg <= traw_reg;
            p1_hraw_reg <= hraw_reg;
            p1_tok_reg  <= tok_reg;
            p1_hok_reg  <= (crc_reg == s_tdata);
        end
    end

    // ------------------------------------------------------------------------
    // Stage 2. One multiplier per quantity, registered before the division.
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_valid_reg <= 1'b0;
        end else if (p2_ready) begin
            p2_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (p2_ready && p1_valid_reg) begin
            p2_tprod_reg <= PROD_W'(p1_traw_reg * TEMP_SCALE);
            p2_hprod_reg <= PROD_W'(p1_hraw_reg * HUM_SCALE);
            p2_tok_reg   <= p1_tok_reg;
            p2_hok_reg   <= p1_hok_reg;
        end
    end

    // ------------------------------------------------------------------------
    // Output stage. Division by 65535 is an add of the product and its upper
    // half with a shift; then the offsets are applied and humidity clamped.
    // ------------------------------------------------------------------------
    assign tq        = div65535(p2_tprod_reg);
    assign hq        = div65535(p2_hprod_reg);
    assign temp_wide = {1'b0, tq} - TEMP_OFFSET;
    assign out_temp_next = temp_wide[14:0];

    always_comb begin
        priority if (hq < HUM_OFFSET) begin
            out_hum_next = '0;
        end else if ((hq - HUM_OFFSET) > {1'b0, HUM_MAX}) begin
            out_hum_next = HUM_MAX;
        end else begin
            out_hum_next = 14'(hq - HUM_OFFSET);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_ready) begin
            out_valid_reg <= p2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready && p2_valid_reg) begin
            out_temp_reg <= out_temp_next;
            out_hum_reg  <= out_hum_next;
            out_tok_reg  <= p2_tok_reg;
            out_hok_reg  <= p2_hok_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_hum_reg, out_temp_reg};
    assign m_tuser  = {out_hok_reg, out_tok_reg};

    // ------------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------------
    // The byte position never leaves the six-byte frame.
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= POS_HUM_CRC)
        else $error("byte position beyond the frame");

    // Each word's CRC starts from its initial value.
    a_crc_init: assert property (@(posedge aclk) disable iff (!aresetn)
        (pos_reg == POS_TEMP_MSB || pos_reg == POS_HUM_MSB) |-> crc_reg == CRC_INIT)
        else $error("CRC not at its initial value at the start of a word");

    // The last byte of a frame wraps the position and fills stage 1.
    a_frame_end: assert property (@(posedge aclk) disable iff (!aresetn)
        frame_done |=> (pos_reg == POS_TEMP_MSB) && p1_valid_reg)
        else $error("frame end not taken into the pipeline");

    // Humidity of a valid result is always within its saturated range.
    a_hum_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> out_hum_reg <= HUM_MAX)
        else $error("humidity above its upper limit");

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the measurement frame decoder.
// ----------------------------------------------------------------------------
// Bytes are streamed into the decoder in bursts with random gaps, and the
// results are drained under a varying stall pattern. This includes one long
// hold-off, during which the decoder fills up and has to stall its input.
// A tracker class follows the byte position, the CRC and the raw words of
// the frame. From these it works out the reading that is due on each sixth
// byte. Every transfer on the result channel is then checked field by field
// against the oldest reading still pending.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import htfd_pkg::*;

    localparam int RESET_CYCLES = 12;
    localparam int RANDOM_ITEMS = 600;
    // Receiver hold-off, long enough for the decoder to back up to its input.
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AFTER   = 200;
    localparam int DRAIN_CYCLES = 20;
    // Cycles without any transfer before the run is declared hung.
    localparam int IDLE_LIMIT   = 4000;

    // One decoded reading as it appears on the result channel.
    typedef struct {
        logic [14:0] temperature;
        logic [13:0] humidity;
        bit          temp_ok;
        bit          hum_ok;
    } reading_t;

    // Tracks the frame state of the decoder. For each accepted byte it works
    // out the reading, if any, and checks the readings that come back.
    class reading_tracker;
        pos_t        position;
        logic [7:0]  crc;
        logic [15:0] temp_word;
        logic [15:0] hum_word;
        bit          temp_ok;
        reading_t    pending[$];
        int          errors;
        int          bytes_taken;

        function new();
            position    = POS_TEMP_MSB;
            crc         = CRC_INIT;
            temp_word   = '0;
            hum_word    = '0;
            temp_ok     = 1'b0;
            errors      = 0;
            bytes_taken = 0;
        endfunction

        // CRC-8 over one byte, most significant bit first.
        static function logic [7:0] crc_step(logic [7:0] c, logic [7:0] d);
            logic [7:0] r;
            r = c ^ d;
            for (int i = 0; i < 8; i++) begin
                r = r[7] ? ({r[6:0], 1'b0} ^ CRC_POLY) : {r[6:0], 1'b0};
            end
            return r;
        endfunction

        function void take_byte(logic [7:0] b, bit start);
            int unsigned q;
            int          t;
            int          h;
            reading_t    r;
            bytes_taken++;
            // A start flag drops whatever part of a frame has been collected.
            if (start) begin
                position = POS_TEMP_MSB;
                crc      = CRC_INIT;
            end
            case (position)
                POS_TEMP_MSB: begin
                    temp_word[15:8] = b;
                    crc = crc_step(crc, b);
                    position = POS_TEMP_LSB;
                end
                POS_TEMP_LSB: begin
                    temp_word[7:0] = b;
                    crc = crc_step(crc, b);
                    position = POS_TEMP_CRC;
                end
                POS_TEMP_CRC: begin
                    temp_ok = (crc == b);
                    crc = CRC_INIT;
                    position = POS_HUM_MSB;
                end
                POS_HUM_MSB: begin
                    hum_word[15:8] = b;
                    crc = crc_step(crc, b);
                    position = POS_HUM_LSB;
                end
                POS_HUM_LSB: begin
                    hum_word[7:0] = b;
                    crc = crc_step(crc, b);
                    position = POS_HUM_CRC;
                end
                default: begin
                    // Sixth byte: the reading is given even when a CRC failed.
                    r.hum_ok  = (crc == b);
                    r.temp_ok = temp_ok;
                    crc = CRC_INIT;
                    position = POS_TEMP_MSB;
                    q = (32'd17500 * 32'(temp_word)) / 32'd65535;
                    t = -4500 + int'(q);
                    q = (32'd12500 * 32'(hum_word)) / 32'd65535;
                    h = -600 + int'(q);
                    if (h < 0) h = 0;
                    if (h > 10000) h = 10000;
                    r.temperature = t[14:0];
                    r.humidity    = h[13:0];
                    pending.push_back(r);
                end
            endcase
        endfunction

        task report_mismatch(string what, int got, int want);
            errors++;
            $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
        endtask

        task check_reading(logic [31:0] data, logic [1:0] flags);
            reading_t want;
            if (pending.size() == 0) begin
                report_mismatch("reading with none pending", int'($signed(data[14:0])), 0);
                return;
            end
            want = pending.pop_front();
            if (data[14:0] !== want.temperature)
                report_mismatch("temperature", int'($signed(data[14:0])),
                                int'($signed(want.temperature)));
            if (data[28:15] !== want.humidity)
                report_mismatch("humidity", int'(data[28:15]), int'(want.humidity));
            if (data[31:29] !== 3'b000)
                report_mismatch("padding bits", int'(data[31:29]), 0);
            if (flags[0] !== want.temp_ok)
                report_mismatch("temperature CRC flag", int'(flags[0]), int'(want.temp_ok));
            if (flags[1] !== want.hum_ok)
                report_mismatch("humidity CRC flag", int'(flags[1]), int'(want.hum_ok));
        endtask
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;   // [7:0] rx_byte
    logic [0:0]  s_tuser  = 1'b0;    // [0] frame_start
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;            // [14:0] temperature_centi, [28:15] humidity_centi
    logic [1:0]  m_tuser;            // [0] temp_crc_ok, [1] hum_crc_ok

    reading_tracker tracker = new();

    int bytes_sent = 0;
    int burst_left = 0;

    humidity_temp_frame_decoder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #10 aclk = ~aclk;

    // Both channels are observed at the rising edge. An input transfer is
    // noted before a result transfer of the same edge is checked.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) tracker.take_byte(s_tdata, s_tuser[0]);
            if (m_tvalid && m_tready) tracker.check_reading(m_tdata, m_tuser);
        end
    end

    // Offers one byte and waits for its transfer. The sender works in bursts.
    // When a burst runs out, valid is dropped for a random gap before the
    // next byte. A gap of zero keeps valid high, so some stretches carry no
    // idle cycles at all.
    task automatic send_byte(input logic [7:0] b, input bit start);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        burst_left--;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= start;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
    endtask

    function automatic logic [7:0] word_crc(input logic [15:0] w);
        return reading_tracker::crc_step(reading_tracker::crc_step(CRC_INIT, w[15:8]), w[7:0]);
    endfunction

    // Sends a whole frame. A spoiled CRC byte is flipped in at least one bit.
    task automatic send_frame(input bit start, input logic [15:0] tw, input logic [15:0] hw,
                              input bit spoil_t, input bit spoil_h);
        logic [7:0] tc;
        logic [7:0] hc;
        tc = word_crc(tw) ^ (spoil_t ? 8'($urandom_range(1, 255)) : 8'h00);
        hc = word_crc(hw) ^ (spoil_h ? 8'($urandom_range(1, 255)) : 8'h00);
        send_byte(tw[15:8], start);
        send_byte(tw[7:0], 1'b0);
        send_byte(tc, 1'b0);
        send_byte(hw[15:8], 1'b0);
        send_byte(hw[7:0], 1'b0);
        send_byte(hc, 1'b0);
    endtask

    // Raw words are mostly uniform. Now and then a word is taken at the
    // range ends or either side of the humidity clamp points.
    function automatic logic [15:0] pick_word();
        logic [15:0] edges[8] = '{16'h0000, 16'h0001, 16'hFFFE, 16'hFFFF,
                                  16'd3145, 16'd3146, 16'd55578, 16'd55579};
        if ($urandom_range(0, 3) == 0) return edges[$urandom_range(0, 7)];
        return 16'($urandom_range(0, 65535));
    endfunction

    // Result side. The ready pattern changes mode after a random stretch.
    // Once enough bytes have been taken, ready is held low for a long
    // stretch while the sender keeps offering bytes.
    initial begin : receiver
        int mode;
        int left;
        bit held;
        mode = 0;
        left = 0;
        held = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (!held && tracker.bytes_taken >= HOLD_AFTER) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
            end else begin
                if (left == 0) begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(16, 96);
                end
                left--;
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= (left % 4 == 0);
                    default: m_tready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    // Ends the run if neither channel has made a transfer for too long.
    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle = 0;
            else idle++;
        end
        $display("humidity_temp_frame_decoder test failed");
        $finish;
    end

    initial begin : stimulus
        int first;
        int n;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part. The first frame relies on the reset position, and
        // the second relies on the wrap after a complete frame. Both carry
        // the extreme raw words, which drive humidity into both clamps.
        // Each CRC flag is seen to fail at least once.
        send_frame(1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0);
        send_frame(1'b0, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
        // A frame cut short by a start flag, which must be dropped quietly.
        send_byte(8'h12, 1'b1);
        send_byte(8'h34, 1'b0);
        send_byte(8'h56, 1'b0);
        send_frame(1'b1, 16'h8000, 16'h6666, 1'b0, 1'b1);

        // Random part: mostly whole frames, with short runs of noise bytes
        // that break the framing.
        first = bytes_sent;
        while (bytes_sent - first < RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) == 0) begin
                n = $urandom_range(1, 5);
                repeat (n) send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
            end else begin
                send_frame($urandom_range(0, 3) != 0, pick_word(), pick_word(),
                           $urandom_range(0, 4) == 0, $urandom_range(0, 4) == 0);
            end
        end
        @(negedge aclk);
        s_tvalid <= 1'b0;

        // Wait for the outstanding readings, then allow a short while for
        // any stray result to show itself.
        while (tracker.pending.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (tracker.pending.size() != 0)
            tracker.report_mismatch("readings never delivered", 0, tracker.pending.size());

        if (tracker.errors == 0) begin
            $display("humidity_temp_frame_decoder test passed");
        end else begin
            $display("humidity_temp_frame_decoder test failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/htfd_pkg.sv
rtl/humidity_temp_frame_decoder.sv
bench/tb_top.sv
